// ===== sv/vumb_pkg.sv =====
// Shared types and constants of the VU meter ballistics block.
package vumb_pkg;

  // Fixed-point layout of the per-channel stages (Q17.16)
  localparam int unsigned VAL_W       = 33;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned COEFF_W     = 20;
  localparam int unsigned COEFF_SHIFT = 24;
  localparam int unsigned CNT_W       = $clog2(COEFF_SHIFT);
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned CHAN_W      = 6;
  localparam int unsigned GROUP       = 4;

  localparam logic [COEFF_W-1:0] COEFF_RESET = 20'd4223;
  localparam logic [LEVEL_W-1:0] UNITY_LEVEL = 16'h8000;
  localparam logic [1:0]         PHASE_LAST  = 2'(GROUP - 1);

  // Command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // Top-level sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RECT,
    ST_ABS,
    ST_FAST,
    ST_SLOW_GO,
    ST_SLOW,
    ST_PEAK,
    ST_WRITE,
    ST_RD_ISSUE,
    ST_RD_WAIT
  } st_e;

  // Serial approach unit sequencer
  typedef enum logic [2:0] {
    AP_IDLE,
    AP_DIFF,
    AP_ABS,
    AP_MUL,
    AP_SUM
  } ap_st_e;

  // One channel's stored state
  typedef struct packed {
    logic [1:0]       phase;
    logic [VAL_W-1:0] peak;
    logic [VAL_W-1:0] slow;
    logic [VAL_W-1:0] fast;
  } ch_state_t;

  // Request to the approach unit
  typedef struct packed {
    logic                   start;
    logic [VAL_W-1:0]       cur;
    logic [VAL_W-1:0]       target;
    logic [COEFF_SHIFT-1:0] coeff;
  } appr_req_t;

  // Status from the approach unit
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] result;
  } appr_rsp_t;

endpackage

// ===== sv/vu_meter_ballistics.sv =====
// A sample passes load, rectify and the fast smoother; every fourth per channel also
// passes the slow smoother and peak update. A read gives CHANNELS results in order,
// waiting while the output stalls. A clear or an ignored item is done on acceptance;
// one item is worked on at a time; the approach unit has a 24-step serial multiply.
// Reset is asynchronous, active low: all channels read as zero, coefficient 4223.
module vu_meter_ballistics
  import vumb_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [19:0]  cfg_data_i,     // smooth_coeff
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // [5:0] channel, [21:6] sample, [23:22] zero
  input  logic [1:0]   s_axis_tuser,   // [1:0] cmd
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // [5:0] out_channel, [21:6] level, [23:22] zero
  output logic         m_axis_tlast    // last
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  st_e state_q, state_d;

  logic [COEFF_W-1:0]  coeff_q;
  logic [CHANNELS-1:0] valid_q;
  logic [CHANNELS-1:0] rearm_q;
  logic [CH_W-1:0]     ch_q;
  logic [CH_W-1:0]     idx_q;
  logic [15:0]         samp_q;
  logic [VAL_W-1:0]    fast_q;
  logic [VAL_W-1:0]    slow_q;
  logic [VAL_W-1:0]    peak_q;
  logic [1:0]          phase_q;
  logic [VAL_W+1:0]    diff_q;
  logic [VAL_W+1:0]    diff_neg;

  logic                out_valid_q;
  logic [CHAN_W-1:0]   out_ch_q;
  logic [LEVEL_W-1:0]  out_lvl_q;
  logic                out_last_q;

  logic                in_acc;
  logic                in_range;
  logic [CH_W-1:0]     in_ch;
  logic                ram_we;
  logic                ram_re;
  logic [CH_W-1:0]     ram_raddr;
  ch_state_t           ram_rdata;
  ch_state_t           ram_wdata;
  ch_state_t           entry;
  appr_req_t           ap_req;
  appr_rsp_t           ap_rsp;
  logic                out_free;
  logic                rd_last;
  logic [VAL_W-1:0]    rd_peak;
  logic [VAL_W-FRAC_BITS-1:0] rd_int;
  logic [LEVEL_W-1:0]  rd_level;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = ({1'b0, s_axis_tdata[5:0]} < 7'(CHANNELS));
  assign in_ch    = s_axis_tdata[CH_W-1:0];
  assign out_free = !out_valid_q || m_axis_tready;
  assign rd_last  = (idx_q == CH_W'(CHANNELS - 1));
  assign diff_neg = (VAL_W+2)'(~diff_q + (VAL_W+2)'(1));

  // Stored entry as seen after clear and rearm
  always_comb begin
    entry = valid_q[ch_q] ? ram_rdata : '0;
    if (rearm_q[ch_q]) begin
      entry.peak = '0;
    end
  end

  // Level of the channel being read: integer part, saturated at unity
  assign rd_peak  = valid_q[idx_q] ? ram_rdata.peak : '0;
  assign rd_int   = rd_peak[VAL_W-1:FRAC_BITS];
  assign rd_level = (rd_int > (VAL_W-FRAC_BITS)'(UNITY_LEVEL)) ? UNITY_LEVEL
                                                             : rd_int[LEVEL_W-1:0];

  assign ram_wdata = '{phase: phase_q, peak: peak_q, slow: slow_q, fast: fast_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == CMD_SAMPLE && in_range) state_d = ST_LOAD;
          else if (s_axis_tuser == CMD_READ)          state_d = ST_RD_ISSUE;
        end
      end
      ST_LOAD:     state_d = ST_RECT;
      ST_RECT:     state_d = ST_ABS;
      ST_ABS:      state_d = ST_FAST;
      ST_FAST: begin
        if (ap_rsp.done) state_d = (phase_q == PHASE_LAST) ? ST_SLOW_GO : ST_WRITE;
      end
      ST_SLOW_GO:  state_d = ST_SLOW;
      ST_SLOW:     if (ap_rsp.done) state_d = ST_PEAK;
      ST_PEAK:     state_d = ST_WRITE;
      ST_WRITE:    state_d = ST_IDLE;
      ST_RD_ISSUE: state_d = ST_RD_WAIT;
      ST_RD_WAIT: begin
        if (out_free) state_d = rd_last ? ST_IDLE : ST_RD_ISSUE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = idx_q;
    ap_req.start  = 1'b0;
    ap_req.cur    = slow_q;
    ap_req.target = fast_q;
    ap_req.coeff  = {2'b00, coeff_q, 2'b00};
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = 1'b1;
        ram_raddr     = in_ch;
      end
      ST_ABS: begin
        ap_req.start  = 1'b1;
        ap_req.cur    = fast_q;
        ap_req.target = diff_q[VAL_W+1] ? diff_neg[VAL_W-1:0] : diff_q[VAL_W-1:0];
        ap_req.coeff  = {4'b0000, coeff_q};
      end
      ST_SLOW_GO:  ap_req.start = 1'b1;
      ST_WRITE:    ram_we = 1'b1;
      ST_RD_ISSUE: ram_re = 1'b1;
      default: begin
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the coefficient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= COEFF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      coeff_q <= cfg_data_i;
    end
  end

  // Track written channels and pending rearms
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rearm_q <= '0;
      idx_q   <= '0;
    end else begin
      if (in_acc && s_axis_tuser == CMD_CLEAR) begin
        valid_q <= '0;
        rearm_q <= '0;
      end
      if (state_q == ST_WRITE) begin
        valid_q[ch_q] <= 1'b1;
        rearm_q[ch_q] <= 1'b0;
      end
      if (state_q == ST_RD_WAIT && out_free) begin
        idx_q <= rd_last ? '0 : idx_q + CH_W'(1);
        if (rd_last) rearm_q <= '1;
      end
    end
  end

  // Sample datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        ch_q   <= in_ch;
        samp_q <= s_axis_tdata[21:6];
      end
      ST_LOAD: begin
        fast_q  <= entry.fast;
        slow_q  <= entry.slow;
        peak_q  <= entry.peak;
        phase_q <= entry.phase;
      end
      ST_RECT: begin
        diff_q <= {{3{samp_q[15]}}, samp_q, 16'h0000} - {3'b000, slow_q[VAL_W-1:1]};
      end
      ST_FAST: begin
        if (ap_rsp.done) begin
          fast_q  <= ap_rsp.result;
          phase_q <= phase_q + 2'd1;
        end
      end
      ST_SLOW: begin
        if (ap_rsp.done) slow_q <= ap_rsp.result;
      end
      ST_PEAK: begin
        if (slow_q > peak_q) peak_q <= slow_q;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RD_WAIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_WAIT && out_free) begin
      out_ch_q   <= CHAN_W'(idx_q);
      out_lvl_q  <= rd_level;
      out_last_q <= rd_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_lvl_q, out_ch_q};
  assign m_axis_tlast  = out_last_q;

  vumb_ram #(
    .WIDTH ($bits(ch_state_t)),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vumb_approach u_approach (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ap_req),
    .rsp_o  (ap_rsp)
  );

`ifndef NO_ASSERTIONS
  a_ready_unit_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ap_rsp.busy)
    else $error("input ready while approach unit busy");

  a_last_channel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == 6'(CHANNELS - 1)))
    else $error("last flag on wrong channel");

  a_level_unity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:6] <= UNITY_LEVEL))
    else $error("level above unity");

  a_clear_all : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == CMD_CLEAR) |=> (valid_q == '0 && rearm_q == '0))
    else $error("clear left channel state");
`endif

endmodule

// ===== sv/vumb_ram.sv =====
// Generic single-port-write, registered-read RAM.
module vumb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/vumb_approach.sv =====
// Bit-serial smoother step: move cur toward target by coeff (Q0.24), truncated.
module vumb_approach
  import vumb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  appr_req_t req_i,
  output appr_rsp_t rsp_o
);

  ap_st_e state_q, state_d;

  logic [VAL_W-1:0]       cur_q;
  logic [VAL_W-1:0]       tgt_q;
  logic [COEFF_SHIFT-1:0] coef_q;
  logic [VAL_W:0]         diff_q;
  logic [VAL_W-1:0]       mag_q;
  logic [VAL_W-1:0]       acc_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [VAL_W:0]         diff_neg;
  logic [VAL_W:0]         acc_sum;
  logic                   last_step;

  assign diff_neg  = (VAL_W+1)'(~diff_q + (VAL_W+1)'(1));
  assign acc_sum   = {1'b0, acc_q} + (coef_q[0] ? {1'b0, mag_q} : '0);
  assign last_step = (cnt_q == CNT_W'(COEFF_SHIFT - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AP_IDLE: if (req_i.start) state_d = AP_DIFF;
      AP_DIFF: state_d = AP_ABS;
      AP_ABS:  state_d = AP_MUL;
      AP_MUL:  if (last_step) state_d = AP_SUM;
      AP_SUM:  state_d = AP_IDLE;
      default: state_d = AP_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rsp_o.busy   = (state_q != AP_IDLE);
    rsp_o.done   = (state_q == AP_SUM);
    rsp_o.result = diff_q[VAL_W] ? (cur_q - acc_q) : (cur_q + acc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: difference, magnitude, then one coefficient bit per cycle
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      AP_IDLE: begin
        if (req_i.start) begin
          cur_q  <= req_i.cur;
          tgt_q  <= req_i.target;
          coef_q <= req_i.coeff;
        end
      end
      AP_DIFF: begin
        diff_q <= {1'b0, tgt_q} - {1'b0, cur_q};
      end
      AP_ABS: begin
        mag_q <= diff_q[VAL_W] ? diff_neg[VAL_W-1:0] : diff_q[VAL_W-1:0];
        acc_q <= '0;
        cnt_q <= '0;
      end
      AP_MUL: begin
        acc_q  <= acc_sum[VAL_W:1];
        coef_q <= coef_q >> 1;
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      AP_SUM: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/tb_vu_meter_ballistics.sv =====
// Self-checking testbench for the VU meter ballistics block, with its own level predictor.
`timescale 1ns / 1ps

module tb_vu_meter_ballistics;
  import vumb_pkg::*;

  localparam int          CHANNELS      = 8;
  localparam int          SETTLE_CYCLES = 80;    // covers the longest sample, one that closes a group of four
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [19:0] COEFF_MAX     = 20'hFFFFF;
  localparam logic [19:0] COEFF_MIN     = 20'd1;
  localparam logic [19:0] COEFF_FROZEN  = 20'd0;

  // One meter report: channel, level and end-of-burst flag
  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } meter_report_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [19:0]  cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata  = '0;   // [5:0] channel, [21:6] sample, [23:22] zero
  logic [1:0]   s_axis_tuser  = '0;   // [1:0] cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;         // [5:0] out_channel, [21:6] level, [23:22] zero
  logic         m_axis_tlast;         // last

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count     = 0;

  // Predictor state
  logic [COEFF_W-1:0] coeff_m;
  logic [VAL_W-1:0]   fast_lvl [CHANNELS];
  logic [VAL_W-1:0]   slow_lvl [CHANNELS];
  logic [VAL_W-1:0]   peak_lvl [CHANNELS];
  logic               rearm_m  [CHANNELS];
  logic [1:0]         group_cnt[CHANNELS];

  meter_report_t report_q[$];

  vu_meter_ballistics #(
    .CHANNELS (CHANNELS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Zero all channel state
  function automatic void clear_meters();
    for (int i = 0; i < CHANNELS; i++) begin
      fast_lvl[i]  = '0;
      slow_lvl[i]  = '0;
      peak_lvl[i]  = '0;
      rearm_m[i]   = 1'b0;
      group_cnt[i] = '0;
    end
  endfunction

  // Move cur toward target by rate (Q0.24), step magnitude truncated
  function automatic logic [VAL_W-1:0] step_toward(logic [VAL_W-1:0] cur,
                                                   logic [VAL_W-1:0] target,
                                                   logic [63:0] rate);
    logic [63:0] cur64;
    logic [63:0] tgt64;
    logic [63:0] delta;
    logic [63:0] sum;
    cur64 = {31'b0, cur};
    tgt64 = {31'b0, target};
    if (tgt64 >= cur64) begin
      delta = ((tgt64 - cur64) * rate) >> COEFF_SHIFT;
      sum   = cur64 + delta;
    end else begin
      delta = ((cur64 - tgt64) * rate) >> COEFF_SHIFT;
      sum   = cur64 - delta;
    end
    return sum[VAL_W-1:0];
  endfunction

  // Advance the predictor by one accepted item and queue its reports
  function automatic void predict_meters(logic [1:0] cmd, logic [CHAN_W-1:0] chan,
                                         logic [15:0] smp);
    logic signed [63:0] scaled;
    logic signed [63:0] half;
    logic signed [63:0] diff;
    logic [63:0]        rect;
    logic [63:0]        whole;
    meter_report_t      rpt;
    case (cmd)
      CMD_SAMPLE: begin
        if (chan < CHANNELS) begin
          if (rearm_m[chan]) begin
            peak_lvl[chan] = '0;
            rearm_m[chan]  = 1'b0;
          end
          scaled = {{48{smp[15]}}, smp};
          scaled = scaled <<< FRAC_BITS;
          half   = {32'b0, slow_lvl[chan][VAL_W-1:1]};
          diff   = scaled - half;
          rect   = (diff < 0) ? -diff : diff;
          fast_lvl[chan]  = step_toward(fast_lvl[chan], rect[VAL_W-1:0], 64'(coeff_m));
          group_cnt[chan] = group_cnt[chan] + 2'd1;
          if (group_cnt[chan] == 2'(GROUP)) begin
            slow_lvl[chan] = step_toward(slow_lvl[chan], fast_lvl[chan],
                                         64'(coeff_m) << 2);
            if (slow_lvl[chan] > peak_lvl[chan]) peak_lvl[chan] = slow_lvl[chan];
          end
        end
      end
      CMD_READ: begin
        for (int i = 0; i < CHANNELS; i++) begin
          whole     = {31'b0, peak_lvl[i]} >> FRAC_BITS;
          rpt.chan  = CHAN_W'(i);
          rpt.level = (whole > 64'(UNITY_LEVEL)) ? UNITY_LEVEL : whole[LEVEL_W-1:0];
          rpt.last  = (i == CHANNELS - 1);
          report_q.push_back(rpt);
          rearm_m[i] = 1'b1;
        end
      end
      CMD_CLEAR: clear_meters();
      default: ;
    endcase
  endfunction

  // Offer one item after a random gap; keep tvalid high for a following item
  task automatic send_item(logic [1:0] cmd, logic [CHAN_W-1:0] chan, logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, smp, chan};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_meters(cmd, chan, smp);
  endtask

  // Hold off the sender until all reports are in and the block has settled
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the smoothing coefficient while the block is idle
  task automatic write_smooth_coeff(logic [19:0] value);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    coeff_m = value;
  endtask

  // Compare each accepted report with the oldest expectation
  always @(posedge clk_i) begin
    meter_report_t exp_rpt;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report chan %0d level %0d last %0b", $time,
                 m_axis_tdata[5:0], m_axis_tdata[21:6], m_axis_tlast);
        err_count++;
      end else begin
        exp_rpt = report_q.pop_front();
        if (m_axis_tdata[5:0] !== exp_rpt.chan) begin
          $display("%0t: out_channel expected %0d actual %0d", $time,
                   exp_rpt.chan, m_axis_tdata[5:0]);
          err_count++;
        end
        if (m_axis_tdata[21:6] !== exp_rpt.level) begin
          $display("%0t: level of chan %0d expected %0d actual %0d", $time,
                   exp_rpt.chan, exp_rpt.level, m_axis_tdata[21:6]);
          err_count++;
        end
        if (m_axis_tlast !== exp_rpt.last) begin
          $display("%0t: last of chan %0d expected %0b actual %0b", $time,
                   exp_rpt.chan, exp_rpt.last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // Read straight after reset: all meters at zero
  task automatic test_power_up_read();
    send_item(CMD_READ, '0, '0);
  endtask

  // Full-scale and near-zero samples on the edge channels, then a fast coefficient
  task automatic test_sample_extremes();
    send_item(CMD_SAMPLE, 6'd0, 16'h7FFF);
    send_item(CMD_SAMPLE, 6'd0, 16'h8000);
    send_item(CMD_SAMPLE, 6'd0, 16'h0000);
    send_item(CMD_SAMPLE, 6'd0, 16'hFFFF);
    repeat (4) send_item(CMD_SAMPLE, 6'd7, 16'h8000);
    send_item(CMD_READ, '0, '0);
    write_smooth_coeff(COEFF_MAX);
    repeat (4) send_item(CMD_SAMPLE, 6'd0, 16'h8000);
    send_item(CMD_READ, '0, '0);
    send_item(CMD_READ, '0, '0);
  endtask

  // First sample after a read drops the held peak
  task automatic test_rearm();
    send_item(CMD_SAMPLE, 6'd0, 16'h0001);
    send_item(CMD_READ, '0, '0);
  endtask

  // Out-of-range channels and the unused command leave the meters alone
  task automatic test_ignored_items();
    send_item(CMD_SAMPLE, 6'd8, 16'h7FFF);
    send_item(CMD_SAMPLE, 6'd63, 16'hFFFF);
    send_item(CMD_UNUSED, 6'd63, 16'hFFFF);
    send_item(CMD_READ, '0, '0);
  endtask

  // Clear zeroes every stage
  task automatic test_clear();
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_READ, '0, '0);
  endtask

  // Zero coefficient freezes both stages; smallest nonzero barely moves them
  task automatic test_coeff_extremes();
    write_smooth_coeff(COEFF_FROZEN);
    repeat (4) send_item(CMD_SAMPLE, 6'd3, 16'h8000);
    send_item(CMD_READ, '0, '0);
    write_smooth_coeff(COEFF_MIN);
    repeat (4) send_item(CMD_SAMPLE, 6'd3, 16'h8000);
    send_item(CMD_READ, '0, '0);
  endtask

  // Mostly valid-channel samples, biased to one channel; reads, clears, ignored items mixed in
  task automatic test_random_traffic(int n_items);
    int               sent;
    int               pick;
    logic [CHAN_W-1:0] chan;
    logic [15:0]      smp;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0:       smp = 16'h8000;
        1:       smp = 16'h7FFF;
        default: smp = 16'($urandom);
      endcase
      if (pick < 81) begin
        chan = $urandom_range(1) ? 6'd0 : CHAN_W'($urandom_range(CHANNELS - 1));
        send_item(CMD_SAMPLE, chan, smp);
        sent++;
      end else if (pick < 89) begin
        send_item(CMD_READ, CHAN_W'($urandom), 16'($urandom));
        sent++;
      end else if (pick < 90) begin
        send_item(CMD_CLEAR, CHAN_W'($urandom), 16'($urandom));
        sent++;
      end else if (pick < 96) begin
        send_item(CMD_SAMPLE, CHAN_W'($urandom_range(63, CHANNELS)), smp);
        sent++;
      end else begin
        send_item(CMD_UNUSED, CHAN_W'($urandom), smp);
        sent++;
      end
    end
    send_item(CMD_READ, '0, '0);
  endtask

  initial begin
    coeff_m = COEFF_RESET;
    clear_meters();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 56;
    test_power_up_read();
    test_sample_extremes();
    test_rearm();
    test_ignored_items();
    test_clear();
    test_coeff_extremes();

    write_smooth_coeff(COEFF_MAX);
    test_random_traffic(115);

    write_smooth_coeff(20'($urandom_range(1048575, 1)));
    send_idle_pct = 56;
    recv_idle_pct = 16;
    test_random_traffic(115);

    write_smooth_coeff(20'($urandom_range(1048575, 262144)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(115);

    wait_quiet();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: stops the run with an error report if it hangs
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
